FILE: src/cra_pkg.sv
// Contiguous ring allocator: shared types, constants and the size clamp.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package cra_pkg;

  // Ring capacity limit and field widths
  localparam int MAX_BYTES    = 65536;
  localparam int RING_CAP_INT = (MAX_BYTES < 65536) ? MAX_BYTES : 65536;
  localparam int SIZE_W       = 17;
  localparam int OFF_W        = 16;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [SIZE_W-1:0] RING_CAP = SIZE_W'(RING_CAP_INT);
  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(2);

  // Request codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_BUFFER_SIZE = 1'b0;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the request beat
    logic commit;  // update offsets and load the result register
  } cra_cmd_t;

  // Clamp a written ring size into [2, capacity]
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] s;
    s = v;
    if (s < MIN_SIZE) s = MIN_SIZE;
    if (s > RING_CAP) s = RING_CAP;
    return s;
  endfunction

endpackage

FILE: src/cra_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on cra_pkg for field widths.
`timescale 1ns / 1ps

interface cra_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [cra_pkg::SIZE_W-1:0] size;

  modport source (output valid, output func, output size, input ready);
  modport sink   (input valid, input func, input size, output ready);
endinterface

interface cra_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      granted;
  logic [cra_pkg::OFF_W-1:0]  offset;
  logic [cra_pkg::SIZE_W-1:0] granted_size;

  modport source (output valid, output granted, output offset, output granted_size,
                  input ready);
  modport sink   (input valid, input granted, input offset, input granted_size,
                  output ready);
endinterface

FILE: src/cra_ctrl.sv
// Controller: accepts a request beat, schedules the commit, owns the result valid.
// Depends on cra_pkg.
`timescale 1ns / 1ps

module cra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cra_pkg::cra_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  state_t state;
  logic   out_valid;

  // Handshake and commands
  assign req_ready  = (state == S_IDLE) && !rst;
  assign cmd.load   = req_valid && req_ready;
  // result slot is free or being emptied this cycle
  assign cmd.commit = (state == S_CALC) && (!out_valid || rsp_ready);
  assign rsp_valid  = out_valid;

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) state <= S_CALC;
        end
        S_CALC: begin
          if (cmd.commit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/cra_dpath.sv
// Datapath: ring size register, write/read offsets, allocate/release arithmetic
// and the result register. Depends on cra_pkg.
`timescale 1ns / 1ps

module cra_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  cra_pkg::cra_cmd_t          cmd,
  input  logic                       in_func,
  input  logic [cra_pkg::SIZE_W-1:0] in_size,
  input  logic                       cfg_we,
  input  logic [cra_pkg::SIZE_W-1:0] cfg_wdata,
  output logic [cra_pkg::SIZE_W-1:0] cfg_rdata,
  output logic                       granted,
  output logic [cra_pkg::OFF_W-1:0]  offset,
  output logic [cra_pkg::SIZE_W-1:0] granted_size
);

  localparam int SW = cra_pkg::SIZE_W;
  localparam int OW = cra_pkg::OFF_W;

  // Captured request
  logic          func;
  logic [SW-1:0] size;

  // Ring state; offsets always sit below the ring size
  logic [SW-1:0] buffer_size;
  logic [OW-1:0] wr_off;
  logic [OW-1:0] rd_off;

  logic [SW-1:0] w, r;
  logic [SW-1:0] tail, head_room, gap;
  logic          alloc_ok;
  logic [SW-1:0] alloc_start;
  logic [SW-1:0] alloc_end;
  logic [SW:0]   rel_sum;
  logic [SW-1:0] rel_start;
  logic [SW:0]   rel_end;

  logic          res_ok;
  logic [SW-1:0] res_start;
  logic [SW-1:0] res_got;

  assign w = {1'b0, wr_off};
  assign r = {1'b0, rd_off};

  // Allocation: tail first, then wrap to offset 0; one byte kept before read
  always_comb begin
    tail        = buffer_size - w - {{(SW-1){1'b0}}, (r == '0)};
    head_room   = r - SW'(1);
    gap         = r - w - SW'(1);
    alloc_ok    = 1'b0;
    alloc_start = '0;
    if (size != '0) begin
      if (w >= r) begin
        if (size <= tail) begin
          alloc_ok    = 1'b1;
          alloc_start = w;
        end else if ((r != '0) && (size <= head_room)) begin
          alloc_ok    = 1'b1;
          alloc_start = '0;
        end
      end else if (size <= gap) begin
        alloc_ok    = 1'b1;
        alloc_start = w;
      end
    end
    alloc_end = alloc_start + size;
  end

  // Release: wrap to 0 when the block would run past the end
  always_comb begin
    rel_sum   = {1'b0, r} + {1'b0, size};
    rel_start = (rel_sum > {1'b0, buffer_size}) ? '0 : r;
    rel_end   = {1'b0, rel_start} + {1'b0, size};
  end

  // Result selection
  always_comb begin
    if (func == cra_pkg::FUNC_RELEASE) begin
      res_ok    = 1'b1;
      res_start = rel_start;
      res_got   = '0;
    end else begin
      res_ok    = alloc_ok;
      res_start = alloc_start;
      res_got   = alloc_ok ? size : '0;
    end
  end

  // Request capture and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_func;
      size <= in_size;
    end
    if (cmd.commit) begin
      granted      <= res_ok;
      offset       <= res_start[OW-1:0];
      granted_size <= res_got;
    end
  end

  // Ring size and offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= cra_pkg::RING_CAP;
      wr_off      <= '0;
      rd_off      <= '0;
    end else if (cfg_we) begin
      buffer_size <= cra_pkg::clamp_size(cfg_wdata);
      wr_off      <= '0;
      rd_off      <= '0;
    end else if (cmd.commit) begin
      if (func == cra_pkg::FUNC_RELEASE) begin
        rd_off <= (rel_end >= {1'b0, buffer_size}) ? '0 : rel_end[OW-1:0];
      end else if (alloc_ok) begin
        wr_off <= (alloc_end >= buffer_size) ? '0 : alloc_end[OW-1:0];
      end
    end
  end

  assign cfg_rdata = buffer_size;

endmodule

FILE: src/contiguous_ring_allocator_top.sv
// Contiguous ring allocator, top level. An accepted request is captured first;
// the commit then loads its result into the result register, waiting while a
// stalled response still holds the last result. A new request is taken only after
// the last one commits, but a waiting result does not block accepting the next one.
// Reset (rst, synchronous, active high): ring size 65536, both offsets 0, no result.
// Depends on cra_pkg, cra_if, cra_ctrl, cra_dpath.
`timescale 1ns / 1ps

module contiguous_ring_allocator_top (
  input  logic                       clk,
  input  logic                       rst,
  cra_req_if.sink                    req,
  cra_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cra_pkg::ADDR_W-1:0] paddr,
  input  logic [cra_pkg::DATA_W-1:0] pwdata,
  output logic [cra_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  cra_pkg::cra_cmd_t           cmd;
  logic                        cfg_we;
  logic                        reg_hit;
  logic [cra_pkg::SIZE_W-1:0]  cfg_rdata;

  // APB register decode
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == cra_pkg::REG_BUFFER_SIZE);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? {{(cra_pkg::DATA_W-cra_pkg::SIZE_W){1'b0}}, cfg_rdata}
                           : '0;

  cra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  cra_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_func      (req.func),
    .in_size      (req.size),
    .cfg_we       (cfg_we),
    .cfg_wdata    (pwdata[cra_pkg::SIZE_W-1:0]),
    .cfg_rdata    (cfg_rdata),
    .granted      (rsp.granted),
    .offset       (rsp.offset),
    .granted_size (rsp.granted_size)
  );

endmodule

FILE: src/cra_checker.sv
// Port-level checks for the contiguous ring allocator, bound to the top level.
// Depends on cra_pkg and contiguous_ring_allocator_top.
`timescale 1ns / 1ps

module cra_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_granted,
  input logic [cra_pkg::OFF_W-1:0]  rsp_offset,
  input logic [cra_pkg::SIZE_W-1:0] rsp_granted_size
);

  // Stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted)
      && $stable(rsp_offset) && $stable(rsp_granted_size))
    else $error("response beat changed while stalled");

  // A refused request reports no block
  a_refused: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_granted |-> rsp_offset == '0 && rsp_granted_size == '0)
    else $error("refused request carries an offset or size");

  // A granted block lies inside the ring
  a_in_ring: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_granted |->
      ({2'b00, rsp_offset} + {1'b0, rsp_granted_size}) <= {1'b0, cra_pkg::RING_CAP})
    else $error("granted block runs past the ring");

  // A fresh result follows an accepted request
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("response without a matching request");

endmodule

bind contiguous_ring_allocator_top cra_checker u_cra_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_granted      (rsp.granted),
  .rsp_offset       (rsp.offset),
  .rsp_granted_size (rsp.granted_size)
);
